>>> sv/kr_pkg.sv
// Shared record and cell-control types for the keyed record table.
`timescale 1ns / 1ps

package kr_pkg;

    localparam int KEY_W = 31;
    localparam int PAY_W = 32;

    // Operation codes carried on func
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_DELETE = 2'd2,
        FN_UPDATE = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             avail;
        logic [PAY_W-1:0] payload;
    } rec_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp;      // capture key match for a new request
        logic [KEY_W-1:0] key;      // key searched
        logic             append;   // write new_rec into the slot at the count
        logic             update;   // overwrite the first matching slot
        logic             shift;    // pull neighbor record at and after first match
        rec_t             new_rec;  // record written by append or update
    } cell_ctl_t;

endpackage

>>> sv/keyed_record_table.sv
// Top level of the keyed record table: controller, result register and cell row.
`timescale 1ns / 1ps

// Keyed record table: a compacted table of up to CAPACITY records (key, payload,
// availability flag), held one record per cell in a row of cells. In the cycle a
// request is accepted every cell compares its key in parallel and registers the
// match; in the execute state that follows, once the output register is free, the
// first match is resolved along the cell chain, the insert, update or delete is
// applied (delete shifts every later record down one cell in that same cycle) and
// the result is loaded into the output register. No new request is accepted while
// the controller is in its execute state; a stalled result holds the controller
// there. Slots beyond the fill count are never read, so the store needs no
// clearing after reset.
module keyed_record_table
    import kr_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  func,
    input  logic [30:0] key,
    input  logic [30:0] new_key,
    input  logic [31:0] payload,
    input  logic        avail,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic        record_avail,
    output logic [31:0] record_payload,
    output logic [4:0]  entry_total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic             found_reg;
    logic             record_avail_reg;
    logic [31:0]      record_payload_reg;
    logic [4:0]       entry_total_reg;

    // Request fields held for the execute cycle
    logic [1:0]       func_reg;
    logic [30:0]      new_key_reg;
    logic [31:0]      payload_reg;
    logic             avail_reg;
    logic [30:0]      key_reg;

    logic             accept;
    logic             go;
    logic             hit;
    logic             full;
    cell_ctl_t        ctl;
    rec_t             hit_rec;
    status_t          status_next;
    logic             found_next;
    logic             rd_avail_next;
    logic [31:0]      rd_payload_next;

    logic [CAPACITY:0]   prior;
    logic [CAPACITY-1:0] first;
    rec_t                recs [CAPACITY+1];

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign go        = (state_reg == S_EXEC) && !(rsp_valid_reg && rsp_stall);
    assign hit       = prior[CAPACITY];
    assign full      = count_reg == CNT_W'(CAPACITY);

    // Chain ends
    assign prior[0]       = 1'b0;
    assign recs[CAPACITY] = '0;

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        kr_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .count        (count_reg),
            .prior_in     (prior[i]),
            .neighbor_rec (recs[i+1]),
            .prior_out    (prior[i+1]),
            .first_hit    (first[i]),
            .rec          (recs[i])
        );
    end

    // Select the record of the first match
    always_comb
    begin
        hit_rec = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_rec = hit_rec | (first[i] ? recs[i] : '0);
        end
    end

    // Decide result, writes and next count
    always_comb
    begin
        status_next     = ST_OK;
        found_next      = 1'b0;
        rd_avail_next   = 1'b0;
        rd_payload_next = '0;
        count_next      = count_reg;

        ctl         = '0;
        ctl.cmp     = accept;
        ctl.key     = key;
        ctl.new_rec = '0;

        unique case (func_t'(func_reg))
            FN_INSERT:
            begin
                ctl.new_rec = '{key: key_reg, avail: avail_reg, payload: payload_reg};
                if (hit)
                begin
                    status_next = ST_DUP;
                    found_next  = 1'b1;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.append = go;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_LOOKUP:
            begin
                if (hit)
                begin
                    found_next      = 1'b1;
                    rd_avail_next   = hit_rec.avail;
                    rd_payload_next = hit_rec.payload;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            FN_DELETE:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    ctl.shift  = go;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            FN_UPDATE:
            begin
                ctl.new_rec = '{key: new_key_reg, avail: avail_reg, payload: payload_reg};
                if (hit)
                begin
                    found_next = 1'b1;
                    ctl.update = go;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    // Hold request fields for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            key_reg     <= key;
            new_key_reg <= new_key;
            payload_reg <= payload;
            avail_reg   <= avail;
        end
    end

    // Advance state, count and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                    if (rsp_valid_reg && !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (go)
                    begin
                        state_reg     <= S_IDLE;
                        count_reg     <= count_next;
                        rsp_valid_reg <= 1'b1;
                    end
                    else if (!rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg         <= status_next;
            found_reg          <= found_next;
            record_avail_reg   <= rd_avail_next;
            record_payload_reg <= rd_payload_next;
            entry_total_reg    <= 5'(count_next);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign record_avail   = record_avail_reg;
    assign record_payload = record_payload_reg;
    assign entry_total    = entry_total_reg;

endmodule

>>> sv/kr_cell.sv
// One slot of the table: stored record, match flag and compaction shift.
`timescale 1ns / 1ps

module kr_cell
    import kr_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] count,
    input  logic             prior_in,
    input  rec_t             neighbor_rec,
    output logic             prior_out,
    output logic             first_hit,
    output rec_t             rec
);

    rec_t rec_reg;
    logic match_reg;
    logic occupied;
    logic at_count;

    // Slot position relative to the fill count
    assign occupied = CNT_W'(IDX) < count;
    assign at_count = CNT_W'(IDX) == count;

    // Resolve first match along the chain
    assign first_hit = match_reg & ~prior_in;
    assign prior_out = prior_in | match_reg;
    assign rec       = rec_reg;

    // Capture the key compare when a request is accepted
    always_ff @(posedge clk)
    begin
        if (ctl.cmp)
        begin
            match_reg <= occupied && (rec_reg.key == ctl.key);
        end
    end

    // Write, overwrite or shift down the stored record
    always_ff @(posedge clk)
    begin
        priority if (ctl.shift && prior_out)
        begin
            rec_reg <= neighbor_rec;
        end
        else if (ctl.update && first_hit)
        begin
            rec_reg <= ctl.new_rec;
        end
        else if (ctl.append && at_count)
        begin
            rec_reg <= ctl.new_rec;
        end
    end

endmodule

>>> test/tb_keyed_record_table.sv
// Self-checking testbench for the keyed record table: directed and random requests.
`timescale 1ns / 1ps

module tb_keyed_record_table
    import kr_pkg::*;
();

    localparam int TABLE_DEPTH     = 16;
    localparam int KEY_POOL_SIZE   = 24;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT    = 10;

    // One expected response
    typedef struct packed {
        status_t     status;
        logic        found;
        logic        rec_avail;
        logic [31:0] rec_payload;
        logic [4:0]  total;
    } table_rsp_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        req_valid      = 1'b0;
    logic        req_stall;
    logic [1:0]  func           = FN_LOOKUP;
    logic [30:0] key            = '0;
    logic [30:0] new_key        = '0;
    logic [31:0] payload        = '0;
    logic        avail          = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall      = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic        record_avail;
    logic [31:0] record_payload;
    logic [4:0]  entry_total;

    // Shadow copy of the table
    rec_t        shadow_rec [TABLE_DEPTH];
    int          shadow_count = 0;
    table_rsp_t  pending_rsp [$];

    logic [30:0] key_pool [KEY_POOL_SIZE];
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          hold_cycles = 0;

    keyed_record_table #(
        .CAPACITY (TABLE_DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .key            (key),
        .new_key        (new_key),
        .payload        (payload),
        .avail          (avail),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .found          (found),
        .record_avail   (record_avail),
        .record_payload (record_payload),
        .entry_total    (entry_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it should give
    function automatic table_rsp_t apply_table_op(func_t op, logic [30:0] req_key,
                                                  logic [30:0] req_new_key,
                                                  logic [31:0] req_payload, logic req_avail);
        table_rsp_t rsp;
        int         hit_idx;
        rsp     = '0;
        hit_idx = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit_idx < 0 && shadow_rec[i].key == req_key)
                hit_idx = i;
        end
        if (op == FN_INSERT)
        begin
            if (hit_idx >= 0)
            begin
                rsp.status = ST_DUP;
                rsp.found  = 1'b1;
            end
            else if (shadow_count >= TABLE_DEPTH)
                rsp.status = ST_FULL;
            else
            begin
                shadow_rec[shadow_count] = {req_key, req_avail, req_payload};
                shadow_count++;
            end
        end
        else if (hit_idx < 0)
            rsp.status = ST_MISS;
        else
        begin
            rsp.found = 1'b1;
            case (op)
                FN_LOOKUP:
                begin
                    rsp.rec_avail   = shadow_rec[hit_idx].avail;
                    rsp.rec_payload = shadow_rec[hit_idx].payload;
                end
                FN_DELETE:
                begin
                    // compact: pull every later record down one slot
                    for (int j = hit_idx; j + 1 < shadow_count; j++)
                        shadow_rec[j] = shadow_rec[j + 1];
                    shadow_count--;
                end
                default:
                    shadow_rec[hit_idx] = {req_new_key, req_avail, req_payload};
            endcase
        end
        rsp.status = rsp.status;
        rsp.total  = shadow_count[4:0];
        return rsp;
    endfunction

    // Drive the response stall: long hold-off first, else random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall = 1'b1;
            hold_cycles--;
        end
        else
            rsp_stall = ($urandom_range(99) < stall_pct);
    end

    // Predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_stall === 1'b0)
            pending_rsp.push_back(apply_table_op(func_t'(func), key, new_key, payload, avail));
    end

    // Check every accepted response against the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        table_rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("unexpected response: status %0d total %0d", status, entry_total);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.status || found !== want.found
                    || record_avail !== want.rec_avail
                    || record_payload !== want.rec_payload
                    || entry_total !== want.total)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("mismatch: expected st %0d fnd %0d av %0d pay %h tot %0d, %s",
                                 want.status, want.found, want.rec_avail, want.rec_payload,
                                 want.total,
                                 $sformatf("got st %0d fnd %0d av %0d pay %h tot %0d",
                                           status, found, record_avail, record_payload,
                                           entry_total));
                end
            end
        end
    end

    // Abort when no handshake completes for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("keyed_record_table regression: fail");
                $finish;
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(input func_t op, input logic [30:0] req_key,
                                input logic [30:0] req_new_key, input logic [31:0] req_payload,
                                input logic req_avail);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        func      = op;
        key       = req_key;
        new_key   = req_new_key;
        payload   = req_payload;
        avail     = req_avail;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    // Random request over a small key pool so hits, duplicates and a full table occur
    task automatic send_random_op();
        int          pick;
        func_t       op;
        logic [30:0] req_key;
        logic [30:0] req_new_key;
        pick = $urandom_range(99);
        if (pick < 35)
            op = FN_INSERT;
        else if (pick < 60)
            op = FN_LOOKUP;
        else if (pick < 80)
            op = FN_DELETE;
        else
            op = FN_UPDATE;
        if ($urandom_range(9) == 0)
            req_key = 31'($urandom);
        else
            req_key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        if ($urandom_range(4) == 0)
            req_new_key = 31'($urandom);
        else
            req_new_key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        send_request(op, req_key, req_new_key, $urandom, 1'($urandom));
    endtask

    // Lookup, delete and update on an empty table all miss
    task automatic test_empty_table();
        send_request(FN_LOOKUP, 31'h0, 31'h0, 32'hFFFF_FFFF, 1'b1);
        send_request(FN_DELETE, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_UPDATE, 31'h0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Extreme fields, duplicate insert, update that creates a duplicate key
    task automatic test_basic_ops();
        send_request(FN_INSERT, 31'h0, 31'h7FFF_FFFF, 32'h0, 1'b0);
        send_request(FN_INSERT, 31'h7FFF_FFFF, 31'h0, 32'hFFFF_FFFF, 1'b1);
        send_request(FN_INSERT, 31'h0, 31'h0, 32'h1234_5678, 1'b1);
        send_request(FN_LOOKUP, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_LOOKUP, 31'h2AAA_AAAA, 31'h0, 32'h0, 1'b0);
        send_request(FN_UPDATE, 31'h0, 31'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1);
        send_request(FN_LOOKUP, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_DELETE, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_LOOKUP, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_DELETE, 31'h5555_5555, 31'h0, 32'h0, 1'b0);
    endtask

    // Fill the table, then full and duplicate inserts, deletes with compaction
    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
            send_request(FN_INSERT, 31'(32'h100 + i), 31'h0, $urandom, 1'($urandom));
        send_request(FN_INSERT, 31'h7F, 31'h0, 32'hDEAD_BEEF, 1'b1);
        send_request(FN_INSERT, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_DELETE, 31'h105, 31'h0, 32'h0, 1'b0);
        send_request(FN_DELETE, 31'h7FFF_FFFF, 31'h0, 32'h0, 1'b0);
        send_request(FN_LOOKUP, 31'h10E, 31'h0, 32'h0, 1'b0);
        send_request(FN_INSERT, 31'h7F, 31'h0, 32'hDEAD_BEEF, 1'b1);
    endtask

    // Hold off responses for a long stretch while requests keep coming
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (16)
            send_random_op();
    endtask

    // Random traffic under one idle/stall setting
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int count);
        gap_pct   = sender_idle;
        stall_pct = receiver_stall;
        repeat (count)
            send_random_op();
    endtask

    initial
    begin
        key_pool[0] = 31'h0;
        key_pool[1] = 31'h7FFF_FFFF;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = 31'($urandom);

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_backpressure();
        test_random_traffic(0, 0, 100);
        test_random_traffic(73, 0, 100);
        test_random_traffic(0, 73, 100);
        test_random_traffic(27, 27, 100);

        // Drain outstanding responses
        @(negedge clk);
        req_valid = 1'b0;
        gap_pct   = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (err_count == 0)
            $display("keyed_record_table regression: pass");
        else
            $display("keyed_record_table regression: fail");
        $finish;
    end

endmodule
